@@ rtl/rtfe_pkg.sv @@
`default_nettype none

package rtfe_pkg;

    // Frame constants
    localparam logic [7:0] DELIM_BYTE   = 8'h7E;
    localparam logic [7:0] API_ID_TX    = 8'h10;
    localparam logic [7:0] LEN_OVERHEAD = 8'd14;
    localparam logic [7:0] ZERO_BYTE    = 8'h00;
    localparam logic [7:0] CSUM_BASE    = 8'hFF;

    // Reset values of the configuration registers
    localparam logic [63:0] DEST_ADDRESS_RST = 64'h0013_A200_4032_124F;
    localparam logic [15:0] DEST_NETWORK_RST = 16'hFFFE;

    // Configuration register indexes
    localparam logic CFG_DEST_ADDRESS = 1'b0;
    localparam logic CFG_DEST_NETWORK = 1'b1;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Sequencer steps within one queued beat
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_DELIM   = 5'd0;
    localparam logic [STEP_W-1:0] STEP_LEN_HI  = 5'd1;
    localparam logic [STEP_W-1:0] STEP_LEN_LO  = 5'd2;
    localparam logic [STEP_W-1:0] STEP_API_ID  = 5'd3;
    localparam logic [STEP_W-1:0] STEP_FRAME_ID = 5'd4;
    localparam logic [STEP_W-1:0] STEP_ADDR7   = 5'd5;
    localparam logic [STEP_W-1:0] STEP_ADDR6   = 5'd6;
    localparam logic [STEP_W-1:0] STEP_ADDR5   = 5'd7;
    localparam logic [STEP_W-1:0] STEP_ADDR4   = 5'd8;
    localparam logic [STEP_W-1:0] STEP_ADDR3   = 5'd9;
    localparam logic [STEP_W-1:0] STEP_ADDR2   = 5'd10;
    localparam logic [STEP_W-1:0] STEP_ADDR1   = 5'd11;
    localparam logic [STEP_W-1:0] STEP_ADDR0   = 5'd12;
    localparam logic [STEP_W-1:0] STEP_NET_HI  = 5'd13;
    localparam logic [STEP_W-1:0] STEP_NET_LO  = 5'd14;
    localparam logic [STEP_W-1:0] STEP_RADIUS  = 5'd15;
    localparam logic [STEP_W-1:0] STEP_OPTIONS = 5'd16;
    localparam logic [STEP_W-1:0] STEP_DATA    = 5'd17;
    localparam logic [STEP_W-1:0] STEP_CSUM    = 5'd18;

    // One classified payload beat handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] len;
        logic       first;
        logic       last;
    } entry_t;

endpackage

`default_nettype wire

@@ rtl/rtfe_front.sv @@
`default_nettype none

module rtfe_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire logic                q_full,
    input  wire logic [7:0]          data_byte,
    input  wire logic [7:0]          payload_length,
    output logic                     q_push,
    output rtfe_pkg::entry_t         q_entry
);

    logic       in_frame_reg;
    logic       in_frame_next;
    logic [7:0] bytes_left_reg;
    logic [7:0] bytes_left_next;
    logic       accept;

    assign accept = push && !q_full;
    assign q_push = accept;

    // Classify the beat: frame start, and whether it closes the frame
    always_comb
    begin
        if (!in_frame_reg)
        begin
            if (payload_length == 8'd0)
                bytes_left_next = 8'd0;
            else
                bytes_left_next = payload_length - 8'd1;
        end
        else if (bytes_left_reg != 8'd0)
        begin
            bytes_left_next = bytes_left_reg - 8'd1;
        end
        else
        begin
            bytes_left_next = 8'd0;
        end
        in_frame_next = (bytes_left_next != 8'd0);

        q_entry.data  = data_byte;
        q_entry.len   = payload_length;
        q_entry.first = !in_frame_reg;
        q_entry.last  = (bytes_left_next == 8'd0);
    end

    // Advance frame state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= 8'd0;
        end
        else if (accept)
        begin
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/rtfe_queue.sv @@
`default_nettype none

module rtfe_queue #(
    parameter int DEPTH = rtfe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire rtfe_pkg::entry_t    wr_entry,
    input  wire logic                rd_en,
    output rtfe_pkg::entry_t         rd_entry,
    output logic                     full,
    output logic                     not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rtfe_pkg::entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_entry  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CNT_W'(1);
    end

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_entry;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/rtfe_back.sv @@
`default_nettype none

module rtfe_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic                cfg_index,
    input  wire logic [63:0]         cfg_data,
    input  wire rtfe_pkg::entry_t    head,
    input  wire logic                head_valid,
    output logic                     head_pop,
    input  wire logic                pop,
    output logic                     empty,
    output logic [7:0]               out_byte,
    output logic                     run_last,
    output logic                     frame_end
);

    localparam int SW = rtfe_pkg::STEP_W;

    logic [63:0]   dest_address_reg;
    logic [15:0]   dest_network_reg;
    logic [SW-1:0] step_reg;
    logic [SW-1:0] step_next;
    logic [SW-1:0] eff_step;
    logic [7:0]    sum_reg;
    logic [7:0]    sum_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [7:0]    out_byte_reg;
    logic          run_last_reg;
    logic          frame_end_reg;
    logic          slot_free;
    logic          emit;
    logic [7:0]    emit_byte;
    logic          emit_last;
    logic          emit_csum;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_address_reg <= rtfe_pkg::DEST_ADDRESS_RST;
            dest_network_reg <= rtfe_pkg::DEST_NETWORK_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rtfe_pkg::CFG_DEST_ADDRESS: dest_address_reg <= cfg_data;
                rtfe_pkg::CFG_DEST_NETWORK: dest_network_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // A beat that continues a frame skips the header steps
    assign eff_step  = head.first ? step_reg : SW'(step_reg + rtfe_pkg::STEP_DATA);
    assign slot_free = !out_valid_reg || pop;
    assign emit      = head_valid && slot_free;
    assign emit_csum = (eff_step == rtfe_pkg::STEP_CSUM);
    assign emit_last = emit_csum || ((eff_step == rtfe_pkg::STEP_DATA) && !head.last);
    assign head_pop  = emit && emit_last;

    // Select the byte for the current step
    always_comb
    begin
        unique case (eff_step)
            rtfe_pkg::STEP_DELIM:    emit_byte = rtfe_pkg::DELIM_BYTE;
            rtfe_pkg::STEP_LEN_HI:   emit_byte = rtfe_pkg::ZERO_BYTE;
            rtfe_pkg::STEP_LEN_LO:   emit_byte = head.len + rtfe_pkg::LEN_OVERHEAD;
            rtfe_pkg::STEP_API_ID:   emit_byte = rtfe_pkg::API_ID_TX;
            rtfe_pkg::STEP_FRAME_ID: emit_byte = rtfe_pkg::ZERO_BYTE;
            rtfe_pkg::STEP_ADDR7:    emit_byte = dest_address_reg[63:56];
            rtfe_pkg::STEP_ADDR6:    emit_byte = dest_address_reg[55:48];
            rtfe_pkg::STEP_ADDR5:    emit_byte = dest_address_reg[47:40];
            rtfe_pkg::STEP_ADDR4:    emit_byte = dest_address_reg[39:32];
            rtfe_pkg::STEP_ADDR3:    emit_byte = dest_address_reg[31:24];
            rtfe_pkg::STEP_ADDR2:    emit_byte = dest_address_reg[23:16];
            rtfe_pkg::STEP_ADDR1:    emit_byte = dest_address_reg[15:8];
            rtfe_pkg::STEP_ADDR0:    emit_byte = dest_address_reg[7:0];
            rtfe_pkg::STEP_NET_HI:   emit_byte = dest_network_reg[15:8];
            rtfe_pkg::STEP_NET_LO:   emit_byte = dest_network_reg[7:0];
            rtfe_pkg::STEP_RADIUS:   emit_byte = rtfe_pkg::ZERO_BYTE;
            rtfe_pkg::STEP_OPTIONS:  emit_byte = rtfe_pkg::ZERO_BYTE;
            rtfe_pkg::STEP_DATA:     emit_byte = head.data;
            rtfe_pkg::STEP_CSUM:     emit_byte = rtfe_pkg::CSUM_BASE - sum_reg;
            default:                 emit_byte = rtfe_pkg::ZERO_BYTE;
        endcase
    end

    // Restart the checksum at the API id, add every byte through the payload
    always_comb
    begin
        sum_next = sum_reg;
        if (eff_step == rtfe_pkg::STEP_API_ID)
            sum_next = rtfe_pkg::API_ID_TX;
        else if ((eff_step > rtfe_pkg::STEP_API_ID) && (eff_step <= rtfe_pkg::STEP_DATA))
            sum_next = sum_reg + emit_byte;
    end

    always_comb
    begin
        if (emit_last)
            step_next = '0;
        else
            step_next = step_reg + SW'(1);
        out_valid_next = emit || (out_valid_reg && !pop);
    end

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (emit)
            begin
                step_reg <= step_next;
                sum_reg  <= sum_next;
            end
        end
    end

    // Hold the result beat until popped
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg  <= emit_byte;
            run_last_reg  <= emit_last;
            frame_end_reg <= emit_csum;
        end
    end

    assign empty     = !out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign frame_end = frame_end_reg;

    // Checksum beat always closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_end_reg) |-> run_last_reg)
        else $error("checksum beat without run_last");

    // Sequencer never runs past the checksum step
    assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (eff_step <= rtfe_pkg::STEP_CSUM))
        else $error("sequencer step out of range");

    // A waiting result is not dropped while not popped
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> out_valid_reg)
        else $error("result beat lost");

    // Continuation beats start at the payload step
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && !head.first) |-> (eff_step >= rtfe_pkg::STEP_DATA))
        else $error("continuation beat entered header");

endmodule

`default_nettype wire

@@ rtl/radio_api_transmit_frame_encoder_top.sv @@
// Path: each accepted beat is queued, and its result bytes are registered in the output
// slot before the ports. Throughput: one payload beat per cycle inside a frame while pop
// keeps the slot free; a frame's first beat emits 18 bytes (header plus payload), and a
// closing beat also the checksum. The output sequencer, one byte per cycle when popped,
// sets this rate; a 4-deep queue decouples input. Reset: rst_n clears queue, frame state
// and sequencer at once; address registers return to their default values.
`default_nettype none

module radio_api_transmit_frame_encoder_top #(
    parameter int QUEUE_DEPTH = rtfe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic [7:0]  payload_length,
    input  wire logic        pop,
    output logic             empty,
    output logic [7:0]       out_byte,
    output logic             run_last,
    output logic             frame_end,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data
);

    rtfe_pkg::entry_t q_in;
    rtfe_pkg::entry_t q_head;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_valid;

    assign full = q_full;

    rtfe_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .q_full         (q_full),
        .data_byte      (data_byte),
        .payload_length (payload_length),
        .q_push         (q_push),
        .q_entry        (q_in)
    );

    rtfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (q_push),
        .wr_entry  (q_in),
        .rd_en     (q_pop),
        .rd_entry  (q_head),
        .full      (q_full),
        .not_empty (q_valid)
    );

    rtfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head       (q_head),
        .head_valid (q_valid),
        .head_pop   (q_pop),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .frame_end  (frame_end)
    );

endmodule

`default_nettype wire
